### hdl/trs_pkg.sv
// Shared constants and types for the transport stream PCR restamper.
package trs_pkg;

    localparam int PID_COUNT    = 8192;
    localparam int PACKET_BYTES = 188;

    localparam int PID_W  = 13;
    localparam int PCR_W  = 42;
    localparam int POS_W  = 48;
    localparam int RATE_W = 30;
    localparam int MODE_W = 2;
    localparam int TICK_W = 28;
    localparam int IDX_W  = $clog2(PID_COUNT);
    localparam int HALF_W = POS_W / 2;
    localparam int PROD_W = HALF_W + TICK_W;
    localparam int DVD_W  = POS_W + TICK_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [PID_W-1:0]  NULL_PID       = 13'h1fff;
    localparam logic [TICK_W-1:0] TICKS_PER_BYTE = 28'd216000000;
    localparam logic [PCR_W-1:0]  PCR_WRAP       = 42'd2576980377600;
    localparam logic [RATE_W-1:0] BITRATE_RESET  = 30'd10000000;

    localparam logic REG_STAMP_MODE = 1'b0;
    localparam logic REG_BITRATE    = 1'b1;

    typedef struct packed {
        logic             seen;
        logic [POS_W-1:0] pos;
        logic [PCR_W-1:0] orig;
        logic [PCR_W-1:0] stamp;
    } trs_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } trs_div_stat_t;

endpackage

### hdl/trs_ram.sv
// Generic simple dual-port RAM with registered read.
module trs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/trs_div.sv
// Bit-serial divider: floor(dividend / divisor) reduced modulo the PCR wrap.
module trs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [trs_pkg::DVD_W-1:0]   dividend,
    input  logic [trs_pkg::RATE_W-1:0]  divisor,
    output logic [trs_pkg::PCR_W-1:0]   quotient,
    output trs_pkg::trs_div_stat_t      stat
);
    import trs_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [PCR_W-1:0]  q_reg;

    logic [RATE_W-1:0] rate;
    logic [RATE_W:0]   r2;
    logic [RATE_W:0]   r_step;
    logic              ge;
    logic [PCR_W:0]    q2;
    logic [PCR_W:0]    q_step;

    always_comb
    begin
        rate   = (divisor == '0) ? RATE_W'(1) : divisor;
        r2     = {rem_reg, dvd_reg[DVD_W-1]};
        ge     = (r2 >= {1'b0, rate});
        r_step = ge ? (r2 - {1'b0, rate}) : r2;
        q2     = {q_reg, ge};
        q_step = (q2 >= {1'b0, PCR_WRAP}) ? (q2 - {1'b0, PCR_WRAP}) : q2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= r_step[RATE_W-1:0];
            q_reg   <= q_step[PCR_W-1:0];
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != CNT_W'(1) |=> busy_reg)
        else $error("divider stopped early");

    a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> rem_reg < ((divisor == '0) ? RATE_W'(1) : divisor))
        else $error("divider remainder out of range");

endmodule

### hdl/ts_pcr_restamper.sv
// Top level of the transport stream PCR restamper.
//
// channel   dir   fields
// s_axis    in    tdata: pid[12:0], pcr_in[54:13]; tuser: has_pcr
// m_axis    out   tdata: pcr_out[41:0]; tuser: rewrite[0], null_packet[1]
// apb       in    0x0 stamp_mode, 0x4 out_rate
//
// A restamped item runs S_READ, S_MUL_LO, S_MUL_HI, S_DIV_GO, S_DIV_WAIT
// (76-step bit-serial divider), S_SUM, S_FIN; others go S_READ, S_FIN.
// After reset a clearing pass writes all PID_COUNT (8192) table rows, one per
// cycle, before the first item is taken.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds in its final step until the output register is free.
module ts_pcr_restamper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // pid[12:0], pcr_in[54:13], zero pad
    input  logic [0:0]  s_axis_tuser,   // has_pcr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pcr_out[41:0], zero pad
    output logic [1:0]  m_axis_tuser,   // rewrite, null_packet
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import trs_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_MUL_LO   = 4'd3;
    localparam logic [3:0] S_MUL_HI   = 4'd4;
    localparam logic [3:0] S_DIV_GO   = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_SUM      = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [MODE_W-1:0] stamp_mode_reg;
    logic [RATE_W-1:0] bitrate_reg;
    logic [POS_W-1:0]  byte_pos_reg;

    logic [PID_W-1:0]  pid_reg;
    logic              has_pcr_reg;
    logic              in_range_reg;
    logic [PCR_W-1:0]  pcr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              hit_reg;
    logic [POS_W-1:0]  elapsed_reg;
    logic [PCR_W-1:0]  base_reg;
    logic [PROD_W-1:0] plo_reg;
    logic [PROD_W-1:0] phi_reg;
    logic [PCR_W:0]    sum_reg;

    logic              out_valid_reg;
    logic [PCR_W-1:0]  out_pcr_reg;
    logic              out_rewrite_reg;
    logic              out_null_reg;

    logic [PID_W-1:0]  s_pid;
    logic [PCR_W-1:0]  s_pcr;
    logic              in_accept;
    logic              out_free;
    logic              cfg_wr;

    trs_entry_t        rd_entry;
    trs_entry_t        wr_entry;
    logic [$bits(trs_entry_t)-1:0] rd_word;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    logic [HALF_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_p;
    logic [DVD_W-1:0]  dividend;
    logic [PCR_W-1:0]  div_q;
    trs_div_stat_t     div_stat;
    logic              div_start;

    logic [PCR_W:0]    red_full;
    logic [PCR_W-1:0]  pcr_res;
    logic              hit_now;

    assign s_pid     = s_axis_tdata[PID_W-1:0];
    assign s_pcr     = s_axis_tdata[PID_W+PCR_W-1:PID_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_STAMP_MODE: prdata = {{(32-MODE_W){1'b0}}, stamp_mode_reg};
            REG_BITRATE:    prdata = {{(32-RATE_W){1'b0}}, bitrate_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_mode_reg <= '0;
            bitrate_reg    <= BITRATE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_STAMP_MODE: stamp_mode_reg <= pwdata[MODE_W-1:0];
                REG_BITRATE:    bitrate_reg    <= pwdata[RATE_W-1:0];
                default:        stamp_mode_reg <= stamp_mode_reg;
            endcase
        end
    end

    assign rd_entry = trs_entry_t'(rd_word);

    trs_ram #(
        .WIDTH ($bits(trs_entry_t)),
        .DEPTH (PID_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (s_pid[IDX_W-1:0]),
        .rd_data (rd_word)
    );

    assign mul_a    = (state_reg == S_MUL_LO) ? elapsed_reg[HALF_W-1:0]
                                              : elapsed_reg[POS_W-1:HALF_W];
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(TICKS_PER_BYTE);
    assign dividend = {phi_reg, {HALF_W{1'b0}}} + DVD_W'(plo_reg);
    assign div_start = (state_reg == S_DIV_GO);

    trs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (bitrate_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign hit_now = has_pcr_reg && in_range_reg && rd_entry.seen
                     && (rd_entry.orig < pcr_reg);

    always_comb
    begin
        red_full = (sum_reg >= {1'b0, PCR_WRAP}) ? (sum_reg - {1'b0, PCR_WRAP}) : sum_reg;
        if (hit_reg)
        begin
            pcr_res = red_full[PCR_W-1:0];
        end
        else if (has_pcr_reg)
        begin
            pcr_res = pcr_reg;
        end
        else
        begin
            pcr_res = '0;
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en    = 1'b1;
            wr_addr  = clr_cnt_reg;
            wr_entry = '0;
        end
        else
        begin
            wr_en          = (state_reg == S_FIN) && out_free && has_pcr_reg && in_range_reg;
            wr_addr        = pid_reg[IDX_W-1:0];
            wr_entry.seen  = 1'b1;
            wr_entry.pos   = pos_reg;
            wr_entry.orig  = pcr_reg;
            wr_entry.stamp = pcr_res;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(PID_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:     state_next = hit_now ? S_MUL_LO : S_FIN;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:      state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            byte_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (in_accept)
            begin
                byte_pos_reg <= byte_pos_reg + POS_W'(PACKET_BYTES);
            end
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pid_reg      <= s_pid;
            has_pcr_reg  <= s_axis_tuser[0];
            in_range_reg <= ((PID_W + 1)'(s_pid) < (PID_W + 1)'(PID_COUNT));
            pcr_reg      <= s_pcr;
            pos_reg      <= byte_pos_reg;
        end
        if (state_reg == S_READ)
        begin
            hit_reg     <= hit_now;
            elapsed_reg <= pos_reg - rd_entry.pos;
            base_reg    <= (rd_entry.stamp >= PCR_WRAP) ? (rd_entry.stamp - PCR_WRAP)
                                                        : rd_entry.stamp;
        end
        if (state_reg == S_MUL_LO)
        begin
            plo_reg <= mul_p;
        end
        if (state_reg == S_MUL_HI)
        begin
            phi_reg <= mul_p;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= {1'b0, base_reg} + {1'b0, div_q};
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            out_pcr_reg     <= pcr_res;
            out_rewrite_reg <= hit_reg && stamp_mode_reg[1];
            out_null_reg    <= (pid_reg == NULL_PID);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(48-PCR_W){1'b0}}, out_pcr_reg};
    assign m_axis_tuser  = {out_null_reg, out_rewrite_reg};

    a_accept_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_READ)
        else $error("accepted item did not start a table read");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait step");

    a_rewrite_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> stamp_mode_reg[1])
        else $error("rewrite flagged in a mode without rewrite");

    a_rewrite_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[PCR_W-1:0] < PCR_WRAP)
        else $error("restamped PCR out of range");

    a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_stat.busy)
        else $error("ready while a division runs");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for ts_pcr_restamper: directed and random packets checked against a predictor.
module tb;
    import trs_pkg::*;

    localparam logic [PCR_W-1:0]  PCR_MAX      = {PCR_W{1'b1}};
    localparam logic [MODE_W-1:0] MODE_REWRITE = 2'd2;
    localparam int POOL_SIZE     = 6;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PCR_W-1:0] pcr;
        logic             rewrite;
        logic             null_pkt;
    } stamp_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             has_pcr;
        logic [PCR_W-1:0] pcr;
        logic             typed;
        stamp_t           want;
    } probe_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;    // pid[12:0], pcr_in[54:13], zero pad
    logic [0:0]  s_axis_tuser  = '0;    // has_pcr
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // pcr_out[41:0], zero pad
    logic [1:0]  m_axis_tuser;          // rewrite, null_packet
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    ts_pcr_restamper dut (.*);

    // predictor state
    logic [MODE_W-1:0] mode_reg = '0;
    logic [RATE_W-1:0] rate_reg = BITRATE_RESET;
    logic [POS_W-1:0]  byte_pos = '0;
    logic              pid_valid [PID_COUNT];
    logic [PCR_W-1:0]  pid_stamp [PID_COUNT];
    logic [PCR_W-1:0]  pid_orig  [PID_COUNT];
    logic [POS_W-1:0]  pid_pos   [PID_COUNT];

    stamp_t           stamp_queue [$];
    logic [PID_W-1:0] pool_pid [POOL_SIZE];
    logic [PCR_W-1:0] pool_pcr [POOL_SIZE];

    int errors       = 0;
    int n_items      = 0;
    int n_results    = 0;
    int n_restamped  = 0;
    int cycles       = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;

    probe_t probe_rows [0:19] = '{
        '{13'h0000, 1'b0, 42'd0,          1'b1, '{42'd0, 1'b0, 1'b0}},
        '{NULL_PID, 1'b0, PCR_MAX,        1'b1, '{42'd0, 1'b0, 1'b1}},
        '{13'h0100, 1'b1, 42'd1000,       1'b1, '{42'd1000, 1'b0, 1'b0}},
        '{13'h0100, 1'b1, 42'd2000,       1'b0, '0},
        '{13'h0100, 1'b1, 42'd2000,       1'b1, '{42'd2000, 1'b0, 1'b0}},
        '{13'h0100, 1'b1, 42'd500,        1'b1, '{42'd500, 1'b0, 1'b0}},
        '{13'h0100, 1'b1, 42'd600,        1'b0, '0},
        '{13'h0000, 1'b1, 42'd0,          1'b1, '{42'd0, 1'b0, 1'b0}},
        '{13'h0000, 1'b1, 42'd1,          1'b0, '0},
        '{NULL_PID, 1'b1, PCR_WRAP - 1,   1'b1, '{PCR_WRAP - 1, 1'b0, 1'b1}},
        '{NULL_PID, 1'b1, PCR_MAX,        1'b0, '0},
        '{13'h0abc, 1'b1, PCR_MAX - 15,   1'b1, '{PCR_MAX - 15, 1'b0, 1'b0}},
        '{13'h0abc, 1'b1, PCR_MAX,        1'b0, '0},
        '{13'h1555, 1'b1, 42'h155_5555_5555, 1'b1, '{42'h155_5555_5555, 1'b0, 1'b0}},
        '{13'h0aaa, 1'b1, 42'h2aa_aaaa_aaaa, 1'b1, '{42'h2aa_aaaa_aaaa, 1'b0, 1'b0}},
        '{13'h0aaa, 1'b0, 42'h155_5555_5555, 1'b1, '{42'd0, 1'b0, 1'b0}},
        '{13'h1555, 1'b1, 42'h2aa_aaaa_aaaa, 1'b0, '0},
        '{13'h0aaa, 1'b1, PCR_MAX - 1,    1'b0, '0},
        '{NULL_PID, 1'b0, 42'd0,          1'b1, '{42'd0, 1'b0, 1'b1}},
        '{NULL_PID, 1'b1, 42'd0,          1'b1, '{42'd0, 1'b0, 1'b1}}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < PID_COUNT; i++)
        begin
            pid_valid[i] = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 20)
        begin
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
    endtask

    function automatic stamp_t restamp(input logic [PID_W-1:0] pid, input logic has_pcr,
                                       input logic [PCR_W-1:0] pcr);
        stamp_t           r;
        logic [POS_W-1:0] gap;
        logic [127:0]     span;
        logic [127:0]     divisor;
        logic [127:0]     ticks;
        logic [PCR_W-1:0] base;
        logic [PCR_W:0]   sum;
        r.pcr      = '0;
        r.rewrite  = 1'b0;
        r.null_pkt = (pid == NULL_PID);
        if (has_pcr)
        begin
            r.pcr = pcr;
            if (int'(pid) < PID_COUNT)
            begin
                if (pid_valid[pid] && pid_orig[pid] < pcr)
                begin
                    gap     = byte_pos - pid_pos[pid];
                    span    = 128'(gap);
                    divisor = (rate_reg == '0) ? 128'd1 : 128'(rate_reg);
                    ticks   = (span * 128'(TICKS_PER_BYTE)) / divisor;
                    ticks   = ticks % 128'(PCR_WRAP);
                    base    = pid_stamp[pid] % PCR_WRAP;
                    sum     = {1'b0, base} + {1'b0, ticks[PCR_W-1:0]};
                    if (sum >= {1'b0, PCR_WRAP})
                    begin
                        sum = sum - {1'b0, PCR_WRAP};
                    end
                    r.pcr     = sum[PCR_W-1:0];
                    r.rewrite = (mode_reg >= MODE_REWRITE);   // modes 2 and 3
                    n_restamped++;
                end
                pid_valid[pid] = 1'b1;
                pid_stamp[pid] = r.pcr;
                pid_orig[pid]  = pcr;
                pid_pos[pid]   = byte_pos;
            end
        end
        byte_pos = byte_pos + POS_W'(PACKET_BYTES);
        return r;
    endfunction

    function automatic probe_t random_probe();
        probe_t p;
        int     slot;
        int     roll;
        p    = '0;
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            slot      = $urandom_range(POOL_SIZE - 1);
            p.pid     = pool_pid[slot];
            p.has_pcr = ($urandom_range(99) < 80);
            if (!p.has_pcr)
            begin
                p.pcr = PCR_W'({$urandom, $urandom});
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    // not greater than the last one: passes through
                    p.pcr = pool_pcr[slot] - PCR_W'($urandom_range(1000));
                end
                else if (roll < 12)
                begin
                    p.pcr = PCR_W'({$urandom, $urandom});
                end
                else
                begin
                    p.pcr = pool_pcr[slot] + PCR_W'($urandom_range(3000000, 1));
                end
                pool_pcr[slot] = p.pcr;
            end
        end
        else
        begin
            p.pid     = PID_W'($urandom);
            p.has_pcr = 1'($urandom_range(1));
            p.pcr     = PCR_W'({$urandom, $urandom});
        end
        return p;
    endfunction

    task automatic send_packet(input probe_t p);
        stamp_t pred;
        while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, p.pcr, p.pid};
        s_axis_tuser  <= p.has_pcr;
        do @(posedge clk); while (!s_axis_tready);
        n_items++;
        pred = restamp(p.pid, p.has_pcr, p.pcr);
        stamp_queue.push_back(p.typed ? p.want : pred);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (stamp_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_register(input logic idx, input logic [31:0] value);
        logic [31:0] held;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_STAMP_MODE)
        begin
            mode_reg = value[MODE_W-1:0];
            held     = 32'(mode_reg);
        end
        else
        begin
            rate_reg = value[RATE_W-1:0];
            held     = 32'(rate_reg);
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== held)
        begin
            report_mismatch("register readback", 64'(prdata), 64'(held));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        stamp_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (stamp_queue.size() == 0)
            begin
                report_mismatch("unexpected item", 64'(m_axis_tdata), 64'd0);
            end
            else
            begin
                want = stamp_queue.pop_front();
                if (m_axis_tdata[PCR_W-1:0] !== want.pcr)
                begin
                    report_mismatch("pcr_out", 64'(m_axis_tdata[PCR_W-1:0]), 64'(want.pcr));
                end
                if (m_axis_tuser[0] !== want.rewrite)
                begin
                    report_mismatch("rewrite", 64'(m_axis_tuser[0]), 64'(want.rewrite));
                end
                if (m_axis_tuser[1] !== want.null_pkt)
                begin
                    report_mismatch("null_packet", 64'(m_axis_tuser[1]), 64'(want.null_pkt));
                end
            end
        end
        m_axis_tready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
    end

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 8;
        rcv_idle_pct = 46;
        set_register(REG_STAMP_MODE, 32'd2);
        set_register(REG_BITRATE, 32'(BITRATE_RESET));
        foreach (probe_rows[i])
        begin
            send_packet(probe_rows[i]);
        end
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    set_register(REG_STAMP_MODE, 32'd3);
                    set_register(REG_BITRATE, 32'd1000000000);
                end
                1:
                begin
                    set_register(REG_STAMP_MODE, 32'd0);
                    set_register(REG_BITRATE, 32'd0);
                end
                2:
                begin
                    snd_idle_pct = 46;
                    rcv_idle_pct = 8;
                    set_register(REG_STAMP_MODE, 32'd1);
                    set_register(REG_BITRATE, 32'd1);
                end
                3:
                begin
                    set_register(REG_STAMP_MODE, 32'd2);
                    set_register(REG_BITRATE, 32'(30'h3fff_ffff));
                end
                4:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    set_register(REG_STAMP_MODE, 32'd3);
                    set_register(REG_BITRATE, $urandom_range(1000000000, 1));
                end
                default:
                begin
                    set_register(REG_STAMP_MODE, 32'd0);
                    set_register(REG_BITRATE, 32'd27000000);
                end
            endcase
            pool_pid[0] = NULL_PID;
            pool_pcr[0] = PCR_W'($urandom);
            for (int i = 1; i < POOL_SIZE; i++)
            begin
                pool_pid[i] = PID_W'($urandom);
                pool_pcr[i] = PCR_W'($urandom);
            end
            repeat (PHASE_ITEMS)
            begin
                send_packet(random_probe());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (stamp_queue.size() != 0)
        begin
            report_mismatch("results never arrived", 64'(stamp_queue.size()), 64'd0);
        end
        $display("%0d packets sent, %0d results checked, %0d PCRs restamped",
                 n_items, n_results, n_restamped);
        $display("pcr modes 0-3, bitrates 0, 1, 1e9 and full scale, three idle profiles");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
